/* rtl/chgs_pkg.sv */
// chgs_pkg: shared constants and state type for the graham scan convex hull block
// used by convex_hull_graham_scan and its port checker
package chgs_pkg;

	localparam int MAX_POINTS_DEF  = 64;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int HULL_SIZE_W     = 7;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_RD_I,
		ST_GOT_I,
		ST_CMP_RD,
		ST_CMP_ADDR,
		ST_CMP_DIFF,
		ST_CMP_MUL1,
		ST_CMP_MUL2,
		ST_CMP_DEC,
		ST_INS,
		ST_SCAN_INIT,
		ST_HL_RD_S,
		ST_HL_RD_P,
		ST_HL_GOT,
		ST_HL_DIFF,
		ST_HL_MUL1,
		ST_HL_MUL2,
		ST_HL_TURN,
		ST_HL_POPRD,
		ST_HL_PUSH,
		ST_EM_RD,
		ST_EM_LOAD
	} chgs_state_t;

endpackage

/* rtl/convex_hull_graham_scan.sv */
// convex_hull_graham_scan: stores points, runs a graham scan, streams the hull; uses chgs_pkg
// input: point words load one per cycle while in_stall is low; after the final one the input
//   stays stalled through the sort, the scan and the streaming of the hull, until the last
//   hull word is taken into the output register
// output: each hull word is read from the stack, then loaded into the output register; an output stall holds it.
// reset (arst_n low) empties the set, clears the internal overflow flag and drops any pending output word
module convex_hull_graham_scan #(
	parameter int MAX_POINTS  = chgs_pkg::MAX_POINTS_DEF,
	parameter int COORD_WIDTH = chgs_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [COORD_WIDTH-1:0]        point_x,
	input  logic signed [COORD_WIDTH-1:0]        point_y,
	input  logic                                 final_point,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [COORD_WIDTH-1:0]        hull_x,
	output logic signed [COORD_WIDTH-1:0]        hull_y,
	output logic [chgs_pkg::HULL_SIZE_W-1:0]     hull_size,
	output logic                                 last_vertex,
	output logic                                 overflow
);

	localparam int IW   = $clog2(MAX_POINTS);
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int CW   = COORD_WIDTH;
	localparam int DW   = COORD_WIDTH + 1;
	localparam int PW   = 2 * DW;
	localparam int MW   = DW + 1;

	// memories: point coordinates, angular sort order, hull stack (coordinates)
	logic [2*CW-1:0] st_mem [MAX_POINTS];
	logic [IW-1:0]   so_mem [MAX_POINTS];
	logic [2*CW-1:0] sk_mem [MAX_POINTS];

	logic [2*CW-1:0] st_rdata_q;
	logic [IW-1:0]   so_rdata_q;
	logic [2*CW-1:0] sk_rdata_q;

	// memory port controls
	logic            st_we, st_re, so_we, so_re, sk_we, sk_re;
	logic [IW-1:0]   st_waddr, st_raddr, so_waddr, so_raddr, sk_waddr, sk_raddr;
	logic [2*CW-1:0] st_wdata, sk_wdata;
	logic [IW-1:0]   so_wdata;

	chgs_pkg::chgs_state_t state_q, state_d;

	// control registers
	logic [CNTW-1:0] count_q, i_q, j_q, m_q, depth_q;
	logic            ovf_q;

	// datapath registers
	logic signed [CW-1:0] piv_x_q, piv_y_q;
	logic signed [CW-1:0] ci_x_q, ci_y_q;
	logic signed [CW-1:0] q_x_q, q_y_q;
	logic signed [CW-1:0] t1_x_q, t1_y_q, t2_x_q, t2_y_q;
	logic signed [DW-1:0] dax_q, day_q, dbx_q, dby_q;
	logic signed [PW-1:0] p1_q, p2_q;

	// output register
	logic                                 out_valid_q;
	logic signed [CW-1:0]                 hull_x_q, hull_y_q;
	logic [chgs_pkg::HULL_SIZE_W-1:0]     hull_size_q;
	logic                                 last_q, ovf_out_q;

	// decoded read data
	logic signed [CW-1:0] st_rx, st_ry, sk_rx, sk_ry;
	assign st_rx = st_rdata_q[2*CW-1:CW];
	assign st_ry = st_rdata_q[CW-1:0];
	assign sk_rx = sk_rdata_q[2*CW-1:CW];
	assign sk_ry = sk_rdata_q[CW-1:0];

	logic in_acc;
	logic store_ok;
	logic new_piv;
	assign in_acc   = in_valid && !in_stall;
	assign store_ok = count_q < CNTW'(MAX_POINTS);
	// smallest x, then smallest y; the first point of a set always takes the pivot
	assign new_piv  = (count_q == '0) || (point_x < piv_x_q) ||
		(point_x == piv_x_q && point_y < piv_y_q);

	// shared multiplier, one product per cycle
	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] mul_p;
	logic                 mul_first;
	assign mul_first = (state_q == chgs_pkg::ST_CMP_MUL1) || (state_q == chgs_pkg::ST_HL_MUL1);
	assign mul_a     = mul_first ? dax_q : day_q;
	assign mul_b     = mul_first ? dby_q : dbx_q;
	assign mul_p     = mul_a * mul_b;

	// cross product sign and distance along the shared ray
	logic signed [PW:0] cross_val;
	logic [DW-1:0]      abs_ax, abs_ay, abs_bx, abs_by;
	logic [MW-1:0]      man_a, man_b;
	logic               a_before_b, turn_bad;
	assign cross_val  = {p1_q[PW-1], p1_q} - {p2_q[PW-1], p2_q};
	assign abs_ax     = dax_q[DW-1] ? DW'(-dax_q) : DW'(dax_q);
	assign abs_ay     = day_q[DW-1] ? DW'(-day_q) : DW'(day_q);
	assign abs_bx     = dbx_q[DW-1] ? DW'(-dbx_q) : DW'(dbx_q);
	assign abs_by     = dby_q[DW-1] ? DW'(-dby_q) : DW'(dby_q);
	// collinear points lie on one ray from the pivot, so manhattan length orders them
	assign man_a      = MW'(abs_ax) + MW'(abs_ay);
	assign man_b      = MW'(abs_bx) + MW'(abs_by);
	assign a_before_b = (!cross_val[PW] && cross_val != '0) ||
		(cross_val == '0 && man_a < man_b);
	assign turn_bad   = cross_val[PW] || cross_val == '0;

	logic [CNTW-1:0] i_inc, j_dec, j_inc;
	assign i_inc = i_q + CNTW'(1);
	assign j_dec = j_q - CNTW'(1);
	assign j_inc = j_q + CNTW'(1);

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			chgs_pkg::ST_LOAD:      if (in_acc && final_point) state_d = chgs_pkg::ST_RD_I;
			chgs_pkg::ST_RD_I:      state_d = chgs_pkg::ST_GOT_I;
			chgs_pkg::ST_GOT_I: begin
				if (st_rx == piv_x_q && st_ry == piv_y_q)
					state_d = (i_inc == count_q) ? chgs_pkg::ST_SCAN_INIT : chgs_pkg::ST_RD_I;
				else if (m_q == '0)
					state_d = chgs_pkg::ST_INS;
				else
					state_d = chgs_pkg::ST_CMP_RD;
			end
			chgs_pkg::ST_CMP_RD:    state_d = chgs_pkg::ST_CMP_ADDR;
			chgs_pkg::ST_CMP_ADDR:  state_d = chgs_pkg::ST_CMP_DIFF;
			chgs_pkg::ST_CMP_DIFF:  state_d = chgs_pkg::ST_CMP_MUL1;
			chgs_pkg::ST_CMP_MUL1:  state_d = chgs_pkg::ST_CMP_MUL2;
			chgs_pkg::ST_CMP_MUL2:  state_d = chgs_pkg::ST_CMP_DEC;
			chgs_pkg::ST_CMP_DEC: begin
				if (a_before_b && j_dec != '0)
					state_d = chgs_pkg::ST_CMP_RD;
				else
					state_d = chgs_pkg::ST_INS;
			end
			chgs_pkg::ST_INS:
				state_d = (i_inc == count_q) ? chgs_pkg::ST_SCAN_INIT : chgs_pkg::ST_RD_I;
			chgs_pkg::ST_SCAN_INIT:
				state_d = (m_q == '0) ? chgs_pkg::ST_EM_RD : chgs_pkg::ST_HL_RD_S;
			chgs_pkg::ST_HL_RD_S:   state_d = chgs_pkg::ST_HL_RD_P;
			chgs_pkg::ST_HL_RD_P:   state_d = chgs_pkg::ST_HL_GOT;
			chgs_pkg::ST_HL_GOT:
				state_d = (depth_q >= CNTW'(2)) ? chgs_pkg::ST_HL_DIFF : chgs_pkg::ST_HL_PUSH;
			chgs_pkg::ST_HL_DIFF:   state_d = chgs_pkg::ST_HL_MUL1;
			chgs_pkg::ST_HL_MUL1:   state_d = chgs_pkg::ST_HL_MUL2;
			chgs_pkg::ST_HL_MUL2:   state_d = chgs_pkg::ST_HL_TURN;
			chgs_pkg::ST_HL_TURN: begin
				if (turn_bad && depth_q >= CNTW'(3))
					state_d = chgs_pkg::ST_HL_POPRD;
				else
					state_d = chgs_pkg::ST_HL_PUSH;
			end
			chgs_pkg::ST_HL_POPRD:  state_d = chgs_pkg::ST_HL_DIFF;
			chgs_pkg::ST_HL_PUSH:
				state_d = (i_inc == m_q) ? chgs_pkg::ST_EM_RD : chgs_pkg::ST_HL_RD_S;
			chgs_pkg::ST_EM_RD:     state_d = chgs_pkg::ST_EM_LOAD;
			chgs_pkg::ST_EM_LOAD: begin
				if (out_free)
					state_d = (j_inc == depth_q) ? chgs_pkg::ST_LOAD : chgs_pkg::ST_EM_RD;
			end
			default:                state_d = chgs_pkg::ST_LOAD;
		endcase
	end

	// memory controls
	always_comb begin
		st_we    = 1'b0;
		st_waddr = count_q[IW-1:0];
		st_wdata = {point_x, point_y};
		st_re    = 1'b0;
		st_raddr = i_q[IW-1:0];
		so_we    = 1'b0;
		so_waddr = j_q[IW-1:0];
		so_wdata = so_rdata_q;
		so_re    = 1'b0;
		so_raddr = j_dec[IW-1:0];
		sk_we    = 1'b0;
		sk_waddr = depth_q[IW-1:0];
		sk_wdata = {q_x_q, q_y_q};
		sk_re    = 1'b0;
		sk_raddr = j_q[IW-1:0];
		unique case (state_q)
			chgs_pkg::ST_LOAD:      st_we = in_acc && store_ok;
			chgs_pkg::ST_RD_I:      st_re = 1'b1;
			chgs_pkg::ST_CMP_RD:    so_re = 1'b1;
			chgs_pkg::ST_CMP_ADDR: begin
				st_re    = 1'b1;
				st_raddr = so_rdata_q;
			end
			chgs_pkg::ST_CMP_DEC:   so_we = a_before_b;
			chgs_pkg::ST_INS: begin
				so_we    = 1'b1;
				so_wdata = i_q[IW-1:0];
			end
			chgs_pkg::ST_SCAN_INIT: begin
				sk_we    = 1'b1;
				sk_waddr = '0;
				sk_wdata = {piv_x_q, piv_y_q};
			end
			chgs_pkg::ST_HL_RD_S: begin
				so_re    = 1'b1;
				so_raddr = i_q[IW-1:0];
			end
			chgs_pkg::ST_HL_RD_P: begin
				st_re    = 1'b1;
				st_raddr = so_rdata_q;
			end
			chgs_pkg::ST_HL_TURN: begin
				// a pop needs the entry that becomes the new second from top
				sk_re    = turn_bad && depth_q >= CNTW'(3);
				sk_raddr = IW'(depth_q - CNTW'(3));
			end
			chgs_pkg::ST_HL_PUSH:   sk_we = 1'b1;
			chgs_pkg::ST_EM_RD:     sk_re = 1'b1;
			default: ;
		endcase
	end

	// synchronous memories, registered read data
	always_ff @(posedge clk) begin
		if (st_we)
			st_mem[st_waddr] <= st_wdata;
		if (st_re)
			st_rdata_q <= st_mem[st_raddr];
		if (so_we)
			so_mem[so_waddr] <= so_wdata;
		if (so_re)
			so_rdata_q <= so_mem[so_raddr];
		if (sk_we)
			sk_mem[sk_waddr] <= sk_wdata;
		if (sk_re)
			sk_rdata_q <= sk_mem[sk_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chgs_pkg::ST_LOAD;
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			m_q     <= '0;
			depth_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				chgs_pkg::ST_LOAD: begin
					if (in_acc) begin
						if (store_ok)
							count_q <= count_q + CNTW'(1);
						else
							ovf_q <= 1'b1;
						i_q <= '0;
						m_q <= '0;
					end
				end
				chgs_pkg::ST_GOT_I: begin
					j_q <= m_q;
					if (st_rx == piv_x_q && st_ry == piv_y_q)
						i_q <= i_inc;
				end
				chgs_pkg::ST_CMP_DEC:   if (a_before_b) j_q <= j_dec;
				chgs_pkg::ST_INS: begin
					m_q <= m_q + CNTW'(1);
					i_q <= i_inc;
				end
				chgs_pkg::ST_SCAN_INIT: begin
					depth_q <= CNTW'(1);
					i_q     <= '0;
					j_q     <= '0;
				end
				chgs_pkg::ST_HL_TURN:   if (turn_bad) depth_q <= depth_q - CNTW'(1);
				chgs_pkg::ST_HL_PUSH: begin
					depth_q <= depth_q + CNTW'(1);
					i_q     <= i_inc;
				end
				chgs_pkg::ST_EM_LOAD: begin
					if (out_free) begin
						j_q <= j_inc;
						if (j_inc == depth_q) begin
							// run done, next word starts a new set
							count_q <= '0;
							depth_q <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			chgs_pkg::ST_LOAD: begin
				if (in_acc && store_ok && new_piv) begin
					piv_x_q <= point_x;
					piv_y_q <= point_y;
				end
			end
			chgs_pkg::ST_GOT_I: begin
				ci_x_q <= st_rx;
				ci_y_q <= st_ry;
			end
			chgs_pkg::ST_CMP_DIFF: begin
				dax_q <= DW'(ci_x_q) - DW'(piv_x_q);
				day_q <= DW'(ci_y_q) - DW'(piv_y_q);
				dbx_q <= DW'(st_rx) - DW'(piv_x_q);
				dby_q <= DW'(st_ry) - DW'(piv_y_q);
			end
			chgs_pkg::ST_CMP_MUL1, chgs_pkg::ST_HL_MUL1: p1_q <= mul_p;
			chgs_pkg::ST_CMP_MUL2, chgs_pkg::ST_HL_MUL2: p2_q <= mul_p;
			chgs_pkg::ST_SCAN_INIT: begin
				t1_x_q <= piv_x_q;
				t1_y_q <= piv_y_q;
			end
			chgs_pkg::ST_HL_GOT: begin
				q_x_q <= st_rx;
				q_y_q <= st_ry;
			end
			chgs_pkg::ST_HL_DIFF: begin
				dax_q <= DW'(t1_x_q) - DW'(t2_x_q);
				day_q <= DW'(t1_y_q) - DW'(t2_y_q);
				dbx_q <= DW'(q_x_q) - DW'(t2_x_q);
				dby_q <= DW'(q_y_q) - DW'(t2_y_q);
			end
			chgs_pkg::ST_HL_TURN: begin
				if (turn_bad) begin
					t1_x_q <= t2_x_q;
					t1_y_q <= t2_y_q;
				end
			end
			chgs_pkg::ST_HL_POPRD: begin
				t2_x_q <= sk_rx;
				t2_y_q <= sk_ry;
			end
			chgs_pkg::ST_HL_PUSH: begin
				t2_x_q <= t1_x_q;
				t2_y_q <= t1_y_q;
				t1_x_q <= q_x_q;
				t1_y_q <= q_y_q;
			end
			default: ;
		endcase
	end

	// output register: the hull word waits here while the next one is fetched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == chgs_pkg::ST_EM_LOAD && out_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == chgs_pkg::ST_EM_LOAD && out_free) begin
			hull_x_q    <= sk_rx;
			hull_y_q    <= sk_ry;
			hull_size_q <= chgs_pkg::HULL_SIZE_W'(depth_q);
			last_q      <= (j_inc == depth_q);
			ovf_out_q   <= ovf_q;
		end
	end

	assign in_stall    = (state_q != chgs_pkg::ST_LOAD);
	assign out_valid   = out_valid_q;
	assign hull_x      = hull_x_q;
	assign hull_y      = hull_y_q;
	assign hull_size   = hull_size_q;
	assign last_vertex = last_q;
	assign overflow    = ovf_out_q;

endmodule

/* rtl/chgs_checker.sv */
// chgs_checker: port-level checks on the convex hull block over time
// depends on chgs_pkg; bound to convex_hull_graham_scan below
module chgs_checker #(
	parameter int COORD_WIDTH = chgs_pkg::COORD_WIDTH_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [COORD_WIDTH-1:0]           hull_x,
	input logic [chgs_pkg::HULL_SIZE_W-1:0] hull_size,
	input logic                             last_vertex
);

	// a stalled output word holds its hull_x and hull_size
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hull_x) && $stable(hull_size))
		else $error("stalled hull word changed");

	// a hull always has at least the pivot
	a_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hull_size != '0)
		else $error("hull word with zero size");

	// while a run is still streaming, no new point is taken
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_vertex |-> in_stall)
		else $error("input open during hull output");

	// all words of one run report the same size
	a_size_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_vertex |=> !out_valid || hull_size == $past(hull_size))
		else $error("hull size changed within a run");

endmodule

bind convex_hull_graham_scan chgs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_chgs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.hull_x      (hull_x),
	.hull_size   (hull_size),
	.last_vertex (last_vertex)
);

/* tb/sv/hull_checker.sv */
`timescale 1ns / 1ps
// hull_checker: watches the point and hull channels of convex_hull_graham_scan,
// predicts the hull of each point set and compares every hull word; uses chgs_pkg
module hull_checker #(
	parameter int MAX_POINTS  = chgs_pkg::MAX_POINTS_DEF,
	parameter int COORD_WIDTH = chgs_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [COORD_WIDTH-1:0]        point_x,
	input  logic signed [COORD_WIDTH-1:0]        point_y,
	input  logic                                 final_point,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [COORD_WIDTH-1:0]        hull_x,
	input  logic signed [COORD_WIDTH-1:0]        hull_y,
	input  logic [chgs_pkg::HULL_SIZE_W-1:0]     hull_size,
	input  logic                                 last_vertex,
	input  logic                                 overflow,
	output int                                   fail_count,
	output int                                   words_pending,
	output int                                   words_checked
);

	typedef struct {
		logic signed [COORD_WIDTH-1:0]    x;
		logic signed [COORD_WIDTH-1:0]    y;
		logic [chgs_pkg::HULL_SIZE_W-1:0] size;
		logic                             lastv;
		logic                             ovf;
	} hull_word_t;

	longint    set_x [MAX_POINTS];
	longint    set_y [MAX_POINTS];
	int        set_len;
	bit        set_ovf;
	hull_word_t hull_expected[$];

	initial begin
		fail_count    = 0;
		words_checked = 0;
		set_len       = 0;
		set_ovf       = 0;
	end

	assign words_pending = hull_expected.size();

	function automatic longint cross3(int a, int b, int c);
		longint bx, by, cx, cy;
		bx = set_x[b] - set_x[a];
		by = set_y[b] - set_y[a];
		cx = set_x[c] - set_x[a];
		cy = set_y[c] - set_y[a];
		return bx * cy - by * cx;
	endfunction

	function automatic longint dist_sq(int p, int a);
		longint dx, dy;
		dx = set_x[a] - set_x[p];
		dy = set_y[a] - set_y[p];
		return dx * dx + dy * dy;
	endfunction

	function automatic bit angle_less(int p, int a, int b);
		longint c;
		c = cross3(p, a, b);
		if (c != 0)
			return c > 0;
		return dist_sq(p, a) < dist_sq(p, b);
	endfunction

	// pivot, stable angular insertion sort, stack scan; queues the hull words
	task automatic predict_hull();
		int order [MAX_POINTS];
		int stk [MAX_POINTS];
		int piv, m, j, depth;
		hull_word_t w;
		piv = 0;
		for (int i = 1; i < set_len; i++)
			if (set_x[i] < set_x[piv] || (set_x[i] == set_x[piv] && set_y[i] < set_y[piv]))
				piv = i;
		m = 0;
		for (int i = 0; i < set_len; i++) begin
			if (set_x[i] == set_x[piv] && set_y[i] == set_y[piv])
				continue;
			j = m;
			while (j > 0 && angle_less(piv, i, order[j-1])) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
			m++;
		end
		stk[0] = piv;
		depth  = 1;
		for (int i = 0; i < m; i++) begin
			while (depth >= 2 && cross3(stk[depth-2], stk[depth-1], order[i]) <= 0)
				depth--;
			stk[depth] = order[i];
			depth++;
		end
		for (int k = 0; k < depth; k++) begin
			w.x     = COORD_WIDTH'(set_x[stk[k]]);
			w.y     = COORD_WIDTH'(set_y[stk[k]]);
			w.size  = chgs_pkg::HULL_SIZE_W'(depth);
			w.lastv = (k == depth - 1);
			w.ovf   = set_ovf;
			hull_expected.insert(hull_expected.size(), w);
		end
		set_len = 0;
		set_ovf = 0;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// point words
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			if (set_len < MAX_POINTS) begin
				set_x[set_len] = point_x;
				set_y[set_len] = point_y;
				set_len++;
			end else
				set_ovf = 1;
			if (final_point)
				predict_hull();
		end
	end

	// hull words
	always @(posedge clk) begin
		hull_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			words_checked++;
			if (hull_expected.size() == 0) begin
				report_mismatch("hull words received", words_checked, words_checked - 1);
			end else begin
				w = hull_expected.pop_front();
				if (hull_x !== w.x)           report_mismatch("hull_x", hull_x, w.x);
				if (hull_y !== w.y)           report_mismatch("hull_y", hull_y, w.y);
				if (hull_size !== w.size)     report_mismatch("hull_size", hull_size, w.size);
				if (last_vertex !== w.lastv)  report_mismatch("last_vertex", last_vertex, w.lastv);
				if (overflow !== w.ovf)       report_mismatch("overflow", overflow, w.ovf);
			end
		end
	end

endmodule

/* tb/sv/tb_convex_hull_graham_scan.sv */
`timescale 1ns / 1ps
// tb_convex_hull_graham_scan: point set stimulus, random idling and verdict
// depends on chgs_pkg, convex_hull_graham_scan and hull_checker
module tb_convex_hull_graham_scan;

	localparam int NPTS      = chgs_pkg::MAX_POINTS_DEF;
	localparam int CW        = chgs_pkg::COORD_WIDTH_DEF;
	localparam int CYC_LIMIT = 2000000;
	localparam int N_WORDS   = 110;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [CW-1:0]          point_x;
	logic signed [CW-1:0]          point_y;
	logic                          final_point;
	logic                          out_valid;
	logic                          out_stall;
	logic signed [CW-1:0]          hull_x;
	logic signed [CW-1:0]          hull_y;
	logic [chgs_pkg::HULL_SIZE_W-1:0] hull_size;
	logic                          last_vertex;
	logic                          overflow;

	int   fail_count, words_pending, words_checked;
	int   words_sent;   // accepted point words
	int   sets_sent;    // completed point sets
	logic no_gaps;      // both sides stop idling while set
	logic hold_out;     // long receiver hold-off
	bit   stim_done;
	longint cycles;

	convex_hull_graham_scan dut (.*);

	hull_checker chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// cycle counter, ends a run that hangs
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYC_LIMIT) begin
				$display("timeout after %0d cycles, %0d hull words still expected",
					cycles, words_pending);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// receiver: random stall at about 37 in 100, none in the calm stretch
	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= hold_out || (!no_gaps && $urandom_range(99) < 37);
	end

	// long hold-off among the small random sets, so the next hull backs up the input
	initial begin
		hold_out = 1'b0;
		wait (sets_sent >= 8);
		@(posedge clk);
		hold_out <= 1'b1;
		repeat (600) @(posedge clk);
		hold_out <= 1'b0;
	end

	// one point word: random idle cycles first, then hold until accepted
	task automatic send_word(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
		input logic fin);
		while (!no_gaps && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		point_x     <= x;
		point_y     <= y;
		final_point <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		if (fin)
			sets_sent++;
	endtask

	// random coordinate: full range, or a tight cluster that breeds ties and collinear runs
	function automatic logic signed [CW-1:0] rand_coord(bit tight);
		if (tight)
			return CW'(int'($urandom_range(6)) - 3);
		return CW'($urandom);
	endfunction

	task automatic send_random_set(int n);
		bit tight;
		tight = ($urandom_range(2) == 0);
		for (int i = 0; i < n; i++)
			send_word(rand_coord(tight), rand_coord(tight), i == n - 1);
	endtask

	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

	initial begin
		int n;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		point_x     = '0;
		point_y     = '0;
		final_point = 1'b0;
		no_gaps     = 1'b0;
		words_sent  = 0;
		sets_sent   = 0;
		stim_done   = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single point: the hull is that point alone
		send_word(CMAX, CMIN, 1'b1);
		// all points equal
		send_word(5, 5, 1'b0);
		send_word(5, 5, 1'b0);
		send_word(5, 5, 1'b1);
		// all collinear: pivot and farthest point
		send_word(2, 2, 1'b0);
		send_word(0, 0, 1'b0);
		send_word(3, 3, 1'b0);
		send_word(1, 1, 1'b1);
		// corners of the coordinate range, inner point, repeated pivot, edge midpoint
		send_word(0, 0, 1'b0);
		send_word(CMAX, CMIN, 1'b0);
		send_word(CMIN, CMIN, 1'b0);
		send_word(CMAX, CMAX, 1'b0);
		send_word(CMIN, CMIN, 1'b0);
		send_word(0, CMAX, 1'b0);
		send_word(CMIN, CMAX, 1'b1);
		// same x as the pivot, ties broken on y; clockwise arrival
		send_word(-1, 4, 1'b0);
		send_word(4, 4, 1'b0);
		send_word(4, -4, 1'b0);
		send_word(-1, -4, 1'b0);
		send_word(-1, 0, 1'b1);

		// overflow: more points than the store holds, the final one ignored too
		n = NPTS + 3;
		for (int i = 0; i < n; i++)
			send_word(CW'($urandom), CW'($urandom), i == n - 1);

		// random small sets, the first two without any idling
		while (words_sent < N_WORDS) begin
			no_gaps <= (sets_sent >= 6 && sets_sent < 8);
			send_random_set($urandom_range(1, 9));
		end
		no_gaps <= 1'b0;
		in_valid <= 1'b0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		@(posedge clk);
		while (words_pending != 0 || hold_out)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d point sets, %0d point words, %0d hull words compared",
			sets_sent, words_sent, words_checked);
		$display("including a single point, coincident and collinear sets, range corners, "
			, "overflow and a long output hold-off");
		if (fail_count == 0 && words_pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/chgs_pkg.sv
rtl/convex_hull_graham_scan.sv
rtl/chgs_checker.sv
tb/sv/hull_checker.sv
tb/sv/tb_convex_hull_graham_scan.sv
